FILE: hw/rtl/programmable_transition_table_fsm_unit_defines.svh
// assertion macros shared by the transition table state machine rtl
// no dependencies
`ifndef PROGRAMMABLE_TRANSITION_TABLE_FSM_UNIT_DEFINES_SVH
`define PROGRAMMABLE_TRANSITION_TABLE_FSM_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptt same-cycle check failed");

// next-cycle implication, checked out of reset
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptt next-cycle check failed");

`endif

FILE: hw/rtl/ptt_pkg.sv
// types and constants for the transition table state machine
// no dependencies
package ptt_pkg;

    localparam int MAX_TRANSITIONS = 16;
    localparam int STATE_BITS      = 6;
    localparam int EVENT_BITS      = 8;
    localparam int IDX_BITS        = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CNT_BITS        = $clog2(MAX_TRANSITIONS + 1);
    localparam int STATUS_BITS     = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_NOTIFY = 2'd2,
        OP_FORCE  = 2'd3
    } op_t;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic                  any;
        logic [STATE_BITS-1:0] src;
        logic [EVENT_BITS-1:0] evt;
        logic [STATE_BITS-1:0] dst;
    } entry_t;

endpackage

FILE: hw/rtl/ptt_ram.sv
// generic single write port ram with registered read
// no dependencies
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/programmable_transition_table_fsm_unit.sv
// transition table state machine: clear, add, notify and force ops, one result per item
// order: clear, add and force go from IDLE to DONE; a notify alternates SCAN and CHECK over
//   the entries, newest first, until a hit or the entries run out, then goes to DONE
// one item at a time, s_ready only in IDLE; the scan is one table read plus one compare a step
// reset (aresetn, synchronous, active low) empties the table and drops the active state
// depends on ptt_pkg, ptt_ram and programmable_transition_table_fsm_unit_defines.svh
`include "programmable_transition_table_fsm_unit_defines.svh"

module programmable_transition_table_fsm_unit
    import ptt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // item input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_op,
    input  logic [EVENT_BITS-1:0]  s_event_id,
    input  logic                   s_from_any,
    input  logic [STATE_BITS-1:0]  s_from_state,
    input  logic [STATE_BITS-1:0]  s_to_state,
    // result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_BITS-1:0] m_status,
    output logic                   m_dispatched,
    output logic [STATE_BITS-1:0]  m_run_state,
    output logic                   m_run_has_event,
    output logic [EVENT_BITS-1:0]  m_run_event,
    output logic                   m_active_valid,
    output logic [STATE_BITS-1:0]  m_current_state
);

    // sequencer: IDLE takes an item, SCAN issues a table read, CHECK compares it,
    // DONE waits for the output register to be free
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } fsm_t;

    fsm_t                   state_reg, state_next;

    // machine state
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [STATE_BITS-1:0]  cur_reg, cur_next;
    logic                   cur_valid_reg, cur_valid_next;

    // scan position, counts down from the newest entry
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic [EVENT_BITS-1:0]  ev_reg, ev_next;

    // result being built for the current item
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic                   res_disp_reg, res_disp_next;
    logic [STATE_BITS-1:0]  res_run_reg, res_run_next;
    logic                   res_has_reg, res_has_next;
    logic [EVENT_BITS-1:0]  res_evt_reg, res_evt_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic                   m_disp_reg, m_disp_next;
    logic [STATE_BITS-1:0]  m_run_reg, m_run_next;
    logic                   m_has_reg, m_has_next;
    logic [EVENT_BITS-1:0]  m_evt_reg, m_evt_next;
    logic                   m_act_valid_reg, m_act_valid_next;
    logic [STATE_BITS-1:0]  m_act_state_reg, m_act_state_next;

    // table memory ports
    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_BITS-1:0]    ram_raddr;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;
    logic [CNT_BITS-1:0]    idx_dec;

    // the shared compare unit
    logic                   hit;

    ptt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_TRANSITIONS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_BITS-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_dec   = idx_reg - CNT_BITS'(1);
    assign ram_raddr = idx_dec[IDX_BITS-1:0];

    // wildcard sources are stored with a zero source id
    always_comb begin
        ram_wdata.any = s_from_any;
        ram_wdata.src = s_from_any ? '0 : s_from_state;
        ram_wdata.evt = s_event_id;
        ram_wdata.dst = s_to_state;
    end

    // entry matches if its source fits the active state and its event fits
    assign hit = (ram_rdata.any || (cur_valid_reg && (ram_rdata.src == cur_reg)))
                 && (ram_rdata.evt == ev_reg);

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cur_next         = cur_reg;
        cur_valid_next   = cur_valid_reg;
        idx_next         = idx_reg;
        ev_next          = ev_reg;
        res_status_next  = res_status_reg;
        res_disp_next    = res_disp_reg;
        res_run_next     = res_run_reg;
        res_has_next     = res_has_reg;
        res_evt_next     = res_evt_reg;
        // a taken result leaves the output register
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_disp_next      = m_disp_reg;
        m_run_next       = m_run_reg;
        m_has_next       = m_has_reg;
        m_evt_next       = m_evt_reg;
        m_act_valid_next = m_act_valid_reg;
        m_act_state_next = m_act_state_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next = ST_OK;
                    res_disp_next   = 1'b0;
                    res_run_next    = '0;
                    res_has_next    = 1'b0;
                    res_evt_next    = '0;
                    state_next      = S_DONE;
                    case (op_t'(s_op))
                        OP_CLEAR: begin
                            cnt_next       = '0;
                            cur_next       = '0;
                            cur_valid_next = 1'b0;
                        end
                        OP_ADD: begin
                            if (cnt_reg == CNT_BITS'(MAX_TRANSITIONS)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_BITS'(1);
                            end
                        end
                        OP_NOTIFY: begin
                            // scan newest to oldest
                            idx_next   = cnt_reg;
                            ev_next    = s_event_id;
                            state_next = S_SCAN;
                        end
                        OP_FORCE: begin
                            res_disp_next  = 1'b1;
                            res_run_next   = s_to_state;
                            cur_next       = s_to_state;
                            cur_valid_next = 1'b1;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg == '0) begin
                    // ran out of entries
                    res_status_next = ST_NOMATCH;
                    state_next      = S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    idx_next   = idx_dec;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hit) begin
                    res_disp_next  = 1'b1;
                    res_run_next   = ram_rdata.dst;
                    res_has_next   = 1'b1;
                    res_evt_next   = ev_reg;
                    cur_next       = ram_rdata.dst;
                    cur_valid_next = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_DONE: begin
                // machine state already holds the post-item value
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_disp_next      = res_disp_reg;
                    m_run_next       = res_run_reg;
                    m_has_next       = res_has_reg;
                    m_evt_next       = res_evt_reg;
                    m_act_valid_next = cur_valid_reg;
                    m_act_state_next = cur_valid_reg ? cur_reg : '0;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        // payload, no reset needed
        idx_reg         <= idx_next;
        ev_reg          <= ev_next;
        res_status_reg  <= res_status_next;
        res_disp_reg    <= res_disp_next;
        res_run_reg     <= res_run_next;
        res_has_reg     <= res_has_next;
        res_evt_reg     <= res_evt_next;
        m_status_reg    <= m_status_next;
        m_disp_reg      <= m_disp_next;
        m_run_reg       <= m_run_next;
        m_has_reg       <= m_has_next;
        m_evt_reg       <= m_evt_next;
        m_act_valid_reg <= m_act_valid_next;
        m_act_state_reg <= m_act_state_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_dispatched    = m_disp_reg;
    assign m_run_state     = m_run_reg;
    assign m_run_has_event = m_has_reg;
    assign m_run_event     = m_evt_reg;
    assign m_active_valid  = m_act_valid_reg;
    assign m_current_state = m_act_state_reg;

    // entry count never passes the table depth
    `PTT_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_BITS'(MAX_TRANSITIONS))
    // an accepted item holds off the next one: s_ready is low in the cycle after acceptance
    `PTT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a dispatch always leaves an active state behind
    `PTT_ASSERT_NOW(a_disp_active, aclk, aresetn, m_valid && m_dispatched, m_active_valid)
    // a result with a status other than ok (full add or failed notify) neither dispatches nor carries an event
    `PTT_ASSERT_NOW(a_nomatch_quiet, aclk, aresetn, m_valid && (m_status != ST_OK), !m_dispatched && !m_run_has_event)

endmodule

FILE: verif/ptt_tb_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the transition table state machine: predicts each result and checks it
// depends on ptt_pkg for the op codes, status codes, widths and table entry type
package ptt_tb_pkg;
    import ptt_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   dispatched;
        logic [STATE_BITS-1:0]  run_state;
        logic                   run_has_event;
        logic [EVENT_BITS-1:0]  run_event;
        logic                   active_valid;
        logic [STATE_BITS-1:0]  current_state;
    } item_outcome_t;

    class transition_scoreboard;
        entry_t                trans_tbl[MAX_TRANSITIONS];
        int                    n_entries;
        logic [STATE_BITS-1:0] act_state;
        logic                  act_valid;
        item_outcome_t         outcome_q[$];
        int unsigned           n_errors;
        int unsigned           n_checked;
        int unsigned           n_op[4];
        int unsigned           n_full;
        int unsigned           n_hit;
        int unsigned           n_miss;

        function new();
            n_entries = 0;
            act_state = '0;
            act_valid = 1'b0;
            n_errors  = 0;
            n_checked = 0;
            n_full    = 0;
            n_hit     = 0;
            n_miss    = 0;
            foreach (n_op[i]) n_op[i] = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // advance the machine by one item and return the result it must give
        function item_outcome_t step_machine(op_t op, logic [EVENT_BITS-1:0] ev, logic wild,
                                             logic [STATE_BITS-1:0] src,
                                             logic [STATE_BITS-1:0] dst);
            item_outcome_t res;
            bit            hit;
            int            i;
            res = '0;
            hit = 1'b0;
            n_op[op]++;
            case (op)
                OP_CLEAR: begin
                    n_entries = 0;
                    act_state = '0;
                    act_valid = 1'b0;
                end
                OP_ADD: begin
                    if (n_entries >= MAX_TRANSITIONS) begin
                        res.status = ST_FULL;
                        n_full++;
                    end else begin
                        trans_tbl[n_entries].any = wild;
                        trans_tbl[n_entries].src = wild ? '0 : src;
                        trans_tbl[n_entries].evt = ev;
                        trans_tbl[n_entries].dst = dst;
                        n_entries++;
                    end
                end
                OP_NOTIFY: begin
                    // newest entry first
                    for (i = n_entries - 1; i >= 0 && !hit; i--) begin
                        if ((trans_tbl[i].any || (act_valid && trans_tbl[i].src == act_state))
                            && trans_tbl[i].evt == ev) begin
                            hit               = 1'b1;
                            res.dispatched    = 1'b1;
                            res.run_state     = trans_tbl[i].dst;
                            res.run_has_event = 1'b1;
                            res.run_event     = ev;
                            act_state         = trans_tbl[i].dst;
                            act_valid         = 1'b1;
                        end
                    end
                    if (hit) begin
                        n_hit++;
                    end else begin
                        res.status = ST_NOMATCH;
                        n_miss++;
                    end
                end
                default: begin
                    res.dispatched = 1'b1;
                    res.run_state  = dst;
                    act_state      = dst;
                    act_valid      = 1'b1;
                end
            endcase
            res.active_valid  = act_valid;
            res.current_state = act_valid ? act_state : '0;
            return res;
        endfunction

        function void take_item(op_t op, logic [EVENT_BITS-1:0] ev, logic wild,
                                logic [STATE_BITS-1:0] src, logic [STATE_BITS-1:0] dst);
            outcome_q.push_back(step_machine(op, ev, wild, src, dst));
        endfunction

        function string show(item_outcome_t r);
            return $sformatf("status=%0d disp=%0d run=%0d has_ev=%0d ev=%0d act_v=%0d act=%0d",
                             r.status, r.dispatched, r.run_state, r.run_has_event,
                             r.run_event, r.active_valid, r.current_state);
        endfunction

        function void check_outcome(item_outcome_t got);
            item_outcome_t exp;
            string         bad;
            bad = "";
            if (outcome_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result with nothing outstanding: %s", show(got));
                return;
            end
            exp = outcome_q.pop_front();
            if (got.status !== exp.status)               bad = {bad, " status"};
            if (got.dispatched !== exp.dispatched)       bad = {bad, " dispatched"};
            if (got.run_state !== exp.run_state)         bad = {bad, " run_state"};
            if (got.run_has_event !== exp.run_has_event) bad = {bad, " run_has_event"};
            if (got.run_event !== exp.run_event)         bad = {bad, " run_event"};
            if (got.active_valid !== exp.active_valid)   bad = {bad, " active_valid"};
            if (got.current_state !== exp.current_state) bad = {bad, " current_state"};
            if (bad != "") begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch on result %0d, fields:%s", n_checked, bad);
                    $display("  expected %s", show(exp));
                    $display("  actual   %s", show(got));
                end
            end
            n_checked++;
        endfunction
    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// top level testbench for programmable_transition_table_fsm_unit: directed items, then
// random table programs and event streams, with random gaps on both handshakes
// depends on ptt_pkg and ptt_tb_pkg (transition_scoreboard)
module tb_top;
    import ptt_pkg::*;
    import ptt_tb_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    // watchdog limit, well above the slowest correct run
    localparam int CYCLE_LIMIT  = 400000;
    // drain margin, covering a notify that misses over all sixteen entries
    localparam int DRAIN_CYCLES = 40;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_op;
    logic [EVENT_BITS-1:0]  s_event_id;
    logic                   s_from_any;
    logic [STATE_BITS-1:0]  s_from_state;
    logic [STATE_BITS-1:0]  s_to_state;
    logic                   m_valid;
    logic                   m_ready;
    logic [STATUS_BITS-1:0] m_status;
    logic                   m_dispatched;
    logic [STATE_BITS-1:0]  m_run_state;
    logic                   m_run_has_event;
    logic [EVENT_BITS-1:0]  m_run_event;
    logic                   m_active_valid;
    logic [STATE_BITS-1:0]  m_current_state;

    transition_scoreboard sb = new();

    // high during the stretch where neither side idles
    bit          steady    = 1'b0;
    int unsigned cycle_cnt = 0;
    int unsigned sent      = 0;

    programmable_transition_table_fsm_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_event_id      (s_event_id),
        .s_from_any      (s_from_any),
        .s_from_state    (s_from_state),
        .s_to_state      (s_to_state),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_dispatched    (m_dispatched),
        .m_run_state     (m_run_state),
        .m_run_has_event (m_run_has_event),
        .m_run_event     (m_run_event),
        .m_active_valid  (m_active_valid),
        .m_current_state (m_current_state)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle with odds of about 32 in a hundred, never during the steady stretch
    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 32);
    endfunction

    // every accepted item goes straight into the prediction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.take_item(op_t'(s_op), s_event_id, s_from_any, s_from_state, s_to_state);
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge aclk) begin
        item_outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status        = m_status;
            got.dispatched    = m_dispatched;
            got.run_state     = m_run_state;
            got.run_has_event = m_run_has_event;
            got.run_event     = m_run_event;
            got.active_valid  = m_active_valid;
            got.current_state = m_current_state;
            sb.check_outcome(got);
        end
    end

    // result side back pressure
    always @(negedge aclk) begin
        m_ready <= !idle_roll();
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one item from a falling edge and hold it until accepted;
    // returns at the falling edge after acceptance
    task automatic send_item(input op_t op, input logic [EVENT_BITS-1:0] ev,
                             input logic wild, input logic [STATE_BITS-1:0] src,
                             input logic [STATE_BITS-1:0] dst);
        while (idle_roll()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_op         <= op;
        s_event_id   <= ev;
        s_from_any   <= wild;
        s_from_state <= src;
        s_to_state   <= dst;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // a well formed program: optional clear, a table built from small pools of
    // states and events so notifies actually hit, an optional force, then events and rare forces
    task automatic run_program();
        logic [STATE_BITS-1:0] st_pool[4];
        logic [EVENT_BITS-1:0] ev_pool[4];
        int                    n_add;
        int                    n_notify;
        int                    k;
        logic                  wild;
        for (k = 0; k < 4; k++) begin
            st_pool[k] = STATE_BITS'($urandom_range(0, 63));
            ev_pool[k] = EVENT_BITS'($urandom_range(0, 255));
        end
        // up to 18 adds so a full table and dropped adds show up regularly
        n_add    = $urandom_range(1, 18);
        n_notify = $urandom_range(4, 16);
        if ($urandom_range(0, 99) < 85)
            send_item(OP_CLEAR, EVENT_BITS'($urandom), 1'($urandom),
                      STATE_BITS'($urandom), STATE_BITS'($urandom));
        for (k = 0; k < n_add; k++) begin
            wild = ($urandom_range(0, 3) == 0);
            send_item(OP_ADD, ev_pool[$urandom_range(0, 3)], wild,
                      wild ? STATE_BITS'($urandom) : st_pool[$urandom_range(0, 3)],
                      st_pool[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 1))
            send_item(OP_FORCE, EVENT_BITS'($urandom), 1'($urandom),
                      STATE_BITS'($urandom), st_pool[$urandom_range(0, 3)]);
        for (k = 0; k < n_notify; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_FORCE, EVENT_BITS'($urandom), 1'($urandom),
                          STATE_BITS'($urandom), st_pool[$urandom_range(0, 3)]);
            else
                send_item(OP_NOTIFY,
                          ($urandom_range(0, 9) == 0) ? EVENT_BITS'($urandom)
                                                      : ev_pool[$urandom_range(0, 3)],
                          1'($urandom), STATE_BITS'($urandom), STATE_BITS'($urandom));
        end
    endtask

    initial begin
        int unsigned rand_base;
        int unsigned last_drain;
        int          k;
        int          n_noise;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_CLEAR;
        s_event_id   = '0;
        s_from_any   = 1'b0;
        s_from_state = '0;
        s_to_state   = '0;
        m_ready      = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        // notify on an empty table with no active state
        send_item(OP_NOTIFY, 8'd0, 1'b0, 6'd0, 6'd0);
        // force to the highest and lowest state ids
        send_item(OP_FORCE, 8'd255, 1'b1, 6'd63, 6'd63);
        send_item(OP_FORCE, 8'd0, 1'b0, 6'd0, 6'd0);
        // clear drops the active state
        send_item(OP_CLEAR, 8'd255, 1'b1, 6'd63, 6'd63);
        // wildcard entry, source bits must be ignored
        send_item(OP_ADD, 8'd255, 1'b1, 6'd63, 6'd63);
        send_item(OP_ADD, 8'd0, 1'b0, 6'd63, 6'd0);
        // no active state: the sourced entry cannot match
        send_item(OP_NOTIFY, 8'd0, 1'b0, 6'd0, 6'd0);
        // wildcard matches with no active state
        send_item(OP_NOTIFY, 8'd255, 1'b0, 6'd0, 6'd0);
        send_item(OP_NOTIFY, 8'd0, 1'b1, 6'd63, 6'd63);
        // a newer wildcard on the same event shadows the sourced entry
        send_item(OP_ADD, 8'd0, 1'b1, 6'd0, 6'd42);
        send_item(OP_NOTIFY, 8'd0, 1'b0, 6'd0, 6'd0);
        // fill the table, then one add too many
        for (k = 0; k < 13; k++)
            send_item(OP_ADD, EVENT_BITS'($urandom), 1'($urandom),
                      STATE_BITS'($urandom), STATE_BITS'($urandom));
        send_item(OP_ADD, 8'd170, 1'b0, 6'd21, 6'd42);
        // full table scan with an event nobody listens to
        send_item(OP_NOTIFY, 8'd85, 1'b1, 6'd42, 6'd21);
        hold_until_drained();

        // random part
        rand_base  = sent;
        last_drain = sent;
        while (sent - rand_base < RANDOM_ITEMS) begin
            steady = (sent - rand_base >= 600) && (sent - rand_base < 900);
            if ($urandom_range(0, 99) < 80) begin
                run_program();
            end else begin
                // noise: any op, any field value
                n_noise = $urandom_range(1, 8);
                for (k = 0; k < n_noise; k++)
                    send_item(op_t'($urandom_range(0, 3)), EVENT_BITS'($urandom),
                              1'($urandom), STATE_BITS'($urandom), STATE_BITS'($urandom));
            end
            if (sent - last_drain >= 400) begin
                hold_until_drained();
                last_drain = sent;
            end
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items, %0d results checked: %0d clears, %0d adds (%0d dropped)",
                 sent, sb.n_checked, sb.n_op[OP_CLEAR], sb.n_op[OP_ADD], sb.n_full);
        $display("%0d notifies (%0d matched, %0d unmatched), %0d forces, %0d errors, %0d left",
                 sb.n_op[OP_NOTIFY], sb.n_hit, sb.n_miss, sb.n_op[OP_FORCE],
                 sb.n_errors, sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/programmable_transition_table_fsm_unit.sv
verif/ptt_tb_pkg.sv
verif/tb_top.sv
